>>> hw/rtl/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RAMP   = 3'd1,
    PH_CRUISE = 3'd2,
    PH_SLOW   = 3'd3,
    PH_BRAKE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_MIN_SPEED        = 3'd0,
    REG_SPEED_STEP       = 3'd1,
    REG_SLOW_DROP        = 3'd2,
    REG_SHORT_MOVE_LIMIT = 3'd3,
    REG_MIN_RAMP_TICKS   = 3'd4
  } reg_index_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] DIR_FORWARD      = 2'd0;
  localparam logic [1:0] DIR_BACKWARD     = 2'd1;
  localparam logic [1:0] DIR_STRAFE_RIGHT = 2'd2;
  localparam logic [1:0] DIR_STRAFE_LEFT  = 2'd3;

  localparam logic [10:0] MIN_SPEED_RESET        = 11'd400;
  localparam logic [7:0]  SPEED_STEP_RESET       = 8'd40;
  localparam logic [10:0] SLOW_DROP_RESET        = 11'd50;
  localparam logic [19:0] SHORT_MOVE_LIMIT_RESET = 20'd200;
  localparam logic [19:0] MIN_RAMP_TICKS_RESET   = 20'd100;

  // exact reciprocals for 20 bit dividends: ceil(2^k / n)
  localparam logic [20:0] RECIP_THREE = 21'd1398102;
  localparam int          SHIFT_THREE = 22;
  localparam logic [20:0] RECIP_FIVE  = 21'd1677722;
  localparam int          SHIFT_FIVE  = 23;

  typedef struct packed {
    logic [10:0] min_speed;
    logic [7:0]  speed_step;
    logic [10:0] slow_drop;
    logic [19:0] short_move_limit;
    logic [19:0] min_ramp_ticks;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [19:0]        distance;
    logic [10:0]        top_speed;
    logic [1:0]         direction;
    logic signed [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] front_left_speed;
    logic signed [11:0] back_left_speed;
    logic signed [11:0] front_right_speed;
    logic signed [11:0] back_right_speed;
    phase_t             phase;
    logic               finished;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/tdp_regs.sv
`default_nettype none
module tdp_regs
  import tdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  reg_index_t idx;
  logic       wr;

  assign idx = reg_index_t'(paddr[4:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_speed        <= MIN_SPEED_RESET;
      cfg.speed_step       <= SPEED_STEP_RESET;
      cfg.slow_drop        <= SLOW_DROP_RESET;
      cfg.short_move_limit <= SHORT_MOVE_LIMIT_RESET;
      cfg.min_ramp_ticks   <= MIN_RAMP_TICKS_RESET;
    end else if (wr) begin
      case (idx)
        REG_MIN_SPEED:        cfg.min_speed        <= pwdata[10:0];
        REG_SPEED_STEP:       cfg.speed_step       <= pwdata[7:0];
        REG_SLOW_DROP:        cfg.slow_drop        <= pwdata[10:0];
        REG_SHORT_MOVE_LIMIT: cfg.short_move_limit <= pwdata[19:0];
        REG_MIN_RAMP_TICKS:   cfg.min_ramp_ticks   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_SPEED:        prdata = {21'b0, cfg.min_speed};
      REG_SPEED_STEP:       prdata = {24'b0, cfg.speed_step};
      REG_SLOW_DROP:        prdata = {21'b0, cfg.slow_drop};
      REG_SHORT_MOVE_LIMIT: prdata = {12'b0, cfg.short_move_limit};
      REG_MIN_RAMP_TICKS:   prdata = {12'b0, cfg.min_ramp_ticks};
      default:              prdata = 32'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/tdp_core.sv
`default_nettype none
module tdp_core
  import tdp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output result_t       res
);

  phase_t      move_phase, phase_next, ph;
  logic [1:0]  move_mode;
  logic [11:0] ramp_speed, ramp_speed_next;
  logic [10:0] cruise_speed;
  logic [19:0] target_ticks, ramp_end, cruise_end;

  // move setup
  logic [40:0] prod_three, prod_five;
  logic [21:0] triple_d;
  logic [19:0] third, long_ramp, quot_five, ramp_len, cruise_len_end;
  logic [20:0] twice_ramp;

  // tick
  logic signed [32:0] pos_ext, prog;
  logic               below_ramp, below_cruise, below_target, active;
  logic [11:0]        cur_clamp, cur_ramp, min_ext, cruise_ext;
  logic [12:0]        ramp_sum;
  logic signed [12:0] slow_diff;
  logic [11:0]        slow_mag, mag;
  logic signed [11:0] speed;
  logic               brake_zero;

  function automatic result_t wheels(input logic [1:0] mode, input logic signed [11:0] s);
    result_t r;
    r = '0;
    r.front_left_speed  = s;
    r.back_left_speed   = s;
    r.front_right_speed = s;
    r.back_right_speed  = s;
    case (mode)
      DIR_FORWARD: ;
      DIR_BACKWARD: begin
        r.front_left_speed  = -s;
        r.back_left_speed   = -s;
        r.front_right_speed = -s;
        r.back_right_speed  = -s;
      end
      DIR_STRAFE_RIGHT: begin
        r.front_left_speed = -s;
        r.back_right_speed = -s;
      end
      default: begin
        r.back_left_speed   = -s;
        r.front_right_speed = -s;
      end
    endcase
    return r;
  endfunction

  // ramp: short d/3, else max(floor(3d/20), min_ramp_ticks)
  always_comb begin
    prod_three = {21'b0, item.distance} * {20'b0, RECIP_THREE};
    third      = {1'b0, prod_three[40:SHIFT_THREE]};
    triple_d   = {1'b0, item.distance, 1'b0} + {2'b0, item.distance};
    prod_five  = {21'b0, triple_d[21:2]} * {20'b0, RECIP_FIVE};
    quot_five  = {2'b0, prod_five[40:SHIFT_FIVE]};
    long_ramp  = (quot_five < cfg.min_ramp_ticks) ? cfg.min_ramp_ticks : quot_five;
    ramp_len   = (item.distance < cfg.short_move_limit) ? third : long_ramp;
    twice_ramp = {ramp_len, 1'b0};
    cruise_len_end = ({1'b0, item.distance} > twice_ramp) ? item.distance - ramp_len
                                                          : ramp_len;
  end

  // progress measure
  always_comb begin
    pos_ext = {item.position[31], item.position};
    case (move_mode)
      DIR_FORWARD:  prog = pos_ext;
      DIR_BACKWARD: prog = -pos_ext;
      default:      prog = pos_ext[32] ? -pos_ext : pos_ext;
    endcase
    below_ramp   = prog < $signed({13'b0, ramp_end});
    below_cruise = prog < $signed({13'b0, cruise_end});
    below_target = prog < $signed({13'b0, target_ticks});
  end

  // next state with phase fall-through
  always_comb begin
    active = move_phase inside {PH_RAMP, PH_CRUISE, PH_SLOW};
    ph = move_phase;
    if (ph == PH_RAMP && !below_ramp) ph = PH_CRUISE;
    if (ph == PH_CRUISE && !below_cruise) ph = PH_SLOW;
    if (ph == PH_SLOW && !below_target) ph = PH_BRAKE;
    if (item.kind == KIND_START) begin
      phase_next = PH_RAMP;
    end else if (!active || ph == PH_BRAKE) begin
      phase_next = PH_IDLE;
    end else begin
      phase_next = ph;
    end
  end

  // speed magnitudes
  always_comb begin
    min_ext    = {1'b0, cfg.min_speed};
    cruise_ext = {1'b0, cruise_speed};
    cur_clamp  = (ramp_speed > cruise_ext) ? cruise_ext : ramp_speed;
    cur_ramp   = (cur_clamp < min_ext && !prog[32]) ? min_ext : cur_clamp;
    ramp_sum   = {1'b0, cur_ramp} + {5'b0, cfg.speed_step};
    slow_diff  = $signed({2'b0, cruise_speed}) - $signed({2'b0, cfg.slow_drop});
    slow_mag   = (slow_diff < $signed({2'b0, cfg.min_speed})) ? min_ext : slow_diff[11:0];
    if (item.kind == KIND_START) begin
      ramp_speed_next = '0;
    end else if (move_phase == PH_RAMP && below_ramp) begin
      ramp_speed_next = ramp_sum[12] ? 12'hFFF : ramp_sum[11:0];
    end else begin
      ramp_speed_next = ramp_speed;
    end
  end

  // result word
  always_comb begin
    case (ph)
      PH_RAMP:   mag = cur_ramp;
      PH_CRUISE: mag = cruise_ext;
      PH_SLOW:   mag = slow_mag;
      default:   mag = '0;
    endcase
    brake_zero = (move_mode == DIR_STRAFE_RIGHT) || (move_mode == DIR_STRAFE_LEFT);
    speed = (ph == PH_BRAKE) ? -$signed(cruise_ext) : $signed(mag);
    if (item.kind == KIND_START) begin
      res       = '0;
      res.phase = PH_RAMP;
    end else if (!active) begin
      res       = '0;
      res.phase = PH_IDLE;
    end else begin
      res = (ph == PH_BRAKE && brake_zero) ? result_t'('0) : wheels(move_mode, speed);
      res.phase    = ph;
      res.finished = (ph == PH_BRAKE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_phase   <= PH_IDLE;
      move_mode    <= '0;
      ramp_speed   <= '0;
      cruise_speed <= '0;
      target_ticks <= '0;
      ramp_end     <= '0;
      cruise_end   <= '0;
    end else if (fire) begin
      move_phase <= phase_next;
      ramp_speed <= ramp_speed_next;
      if (item.kind == KIND_START) begin
        move_mode    <= item.direction;
        cruise_speed <= item.top_speed;
        target_ticks <= item.distance;
        ramp_end     <= ramp_len;
        cruise_end   <= cruise_len_end;
      end
    end
  end

  a_start_loads_ramp: assert property (@(posedge clk) disable iff (rst)
    (fire && item.kind == KIND_START) |=> (move_phase == PH_RAMP && ramp_speed == '0))
    else $error("start word did not load ramp phase");

  a_no_stored_brake: assert property (@(posedge clk) disable iff (rst)
    fire |=> (move_phase != PH_BRAKE))
    else $error("brake phase stored as move state");

  a_finished_on_brake: assert property (@(posedge clk) disable iff (rst)
    (fire && res.finished) |=> (move_phase == PH_IDLE))
    else $error("move did not go idle after finishing");

endmodule
`default_nettype wire

>>> hw/rtl/trapezoid_drive_profile_unit.sv
`default_nettype none
// accepted words wait in the input register; results are registered into m_tdata on advance
// throughput: one word per cycle unless m_tready stalls; each register holds one word
// the per-tick update and the move setup (reciprocal multiplies) sit between those registers
// reset (rst, synchronous): both stages empty, profile idle, config registers at defaults
module trapezoid_drive_profile_unit
  import tdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // distance[19:0], top_speed[30:20], direction[32:31], position[64:33], zero pad
  input  wire logic [71:0] s_tdata,
  // kind[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // front_left[11:0], back_left[23:12], front_right[35:24], back_right[47:36],
  // phase[50:48], zero pad
  output logic [55:0]      m_tdata,
  // finished
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg;
  in_item_t in_item;
  result_t  res;
  logic     in_valid;
  logic     advance;

  assign pready   = 1'b1;
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  tdp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tdp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind      <= s_tuser[0];
      in_item.distance  <= s_tdata[19:0];
      in_item.top_speed <= s_tdata[30:20];
      in_item.direction <= s_tdata[32:31];
      in_item.position  <= s_tdata[64:33];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, res.phase, res.back_right_speed, res.front_right_speed,
                  res.back_left_speed, res.front_left_speed};
      m_tlast <= res.finished;
    end
  end

  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result word lost after advance");

  a_last_is_brake: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[50:48] == PH_BRAKE))
    else $error("finished word without brake phase");

endmodule
`default_nettype wire

>>> bench/drive_profile_checker.sv
module drive_profile_checker
  import tdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  // distance[19:0], top_speed[30:20], direction[32:31], position[64:33], zero pad
  input  wire logic [71:0] s_tdata,
  // kind[0]
  input  wire logic [0:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // front_left[11:0], back_left[23:12], front_right[35:24], back_right[47:36],
  // phase[50:48], zero pad
  input  wire logic [55:0] m_tdata,
  // finished
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               cmds_due
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg;
  phase_t      move_phase;
  logic [1:0]  move_mode;
  logic [11:0] ramp_speed;
  logic [10:0] cruise_speed;
  logic [19:0] target_ticks;
  logic [19:0] ramp_end;
  logic [20:0] cruise_end;

  result_t wheel_cmd_due[$];

  function automatic result_t wheel_cmd(logic [1:0] mode, longint s, phase_t ph, logic fin);
    result_t res;
    longint fl, bl, fr, br;
    fl = s;
    bl = s;
    fr = s;
    br = s;
    case (mode)
      DIR_BACKWARD: begin
        fl = -s;
        bl = -s;
        fr = -s;
        br = -s;
      end
      DIR_STRAFE_RIGHT: begin
        fl = -s;
        br = -s;
      end
      DIR_STRAFE_LEFT: begin
        bl = -s;
        fr = -s;
      end
      default: ;
    endcase
    res.front_left_speed  = fl[11:0];
    res.back_left_speed   = bl[11:0];
    res.front_right_speed = fr[11:0];
    res.back_right_speed  = br[11:0];
    res.phase             = ph;
    res.finished          = fin;
    return res;
  endfunction

  // advances the profile state by one word and returns the wheel command it yields
  function automatic result_t next_wheel_cmd(in_item_t it);
    result_t res;
    longint  d, r, c, pos, prog, mag, cur, nxt, cruise, mn;
    phase_t  ph;
    res = wheel_cmd(DIR_FORWARD, 0, PH_IDLE, 1'b0);
    if (it.kind == KIND_START) begin
      d = it.distance;
      if (d < longint'(cfg.short_move_limit)) begin
        r = d / 3;
      end else begin
        r = (15 * d) / 100;
        if (r < longint'(cfg.min_ramp_ticks)) r = cfg.min_ramp_ticks;
      end
      c = (d > 2 * r) ? d - 2 * r : 0;
      target_ticks = it.distance;
      ramp_end     = r[19:0];
      cruise_end   = 21'(r + c);
      cruise_speed = it.top_speed;
      move_mode    = it.direction;
      ramp_speed   = '0;
      move_phase   = PH_RAMP;
      res = wheel_cmd(DIR_FORWARD, 0, PH_RAMP, 1'b0);
    end else if (move_phase == PH_IDLE || move_phase > PH_SLOW) begin
      move_phase = PH_IDLE;
    end else begin
      pos = longint'($signed(it.position));
      if (move_mode == DIR_FORWARD) prog = pos;
      else if (move_mode == DIR_BACKWARD) prog = -pos;
      else prog = (pos < 0) ? -pos : pos;
      ph     = move_phase;
      cruise = cruise_speed;
      mn     = cfg.min_speed;
      mag    = 0;
      if (ph == PH_RAMP) begin
        if (prog < longint'(ramp_end)) begin
          cur = ramp_speed;
          if (cur > cruise) cur = cruise;
          // a wheel that slipped back below the start keeps the raw ramp value
          if (cur < mn && prog >= 0) cur = mn;
          mag = cur;
          nxt = cur + cfg.speed_step;
          if (nxt > 4095) nxt = 4095;
          ramp_speed = nxt[11:0];
        end else begin
          ph = PH_CRUISE;
        end
      end
      if (ph == PH_CRUISE) begin
        if (prog < longint'(cruise_end)) mag = cruise;
        else ph = PH_SLOW;
      end
      if (ph == PH_SLOW) begin
        if (prog < longint'(target_ticks)) begin
          mag = cruise - longint'(cfg.slow_drop);
          if (mag < mn) mag = mn;
        end else begin
          ph = PH_BRAKE;
        end
      end
      if (ph == PH_BRAKE) begin
        // reverse pulse only for straight moves, strafes just stop
        if (move_mode == DIR_FORWARD || move_mode == DIR_BACKWARD) begin
          res = wheel_cmd(move_mode, -cruise, PH_BRAKE, 1'b1);
        end else begin
          res = wheel_cmd(move_mode, 0, PH_BRAKE, 1'b1);
        end
        move_phase = PH_IDLE;
      end else begin
        res = wheel_cmd(move_mode, mag, ph, 1'b0);
        move_phase = ph;
      end
    end
    return res;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    in_item_t item;
    result_t  want, got;
    if (rst) begin
      cfg.min_speed        = MIN_SPEED_RESET;
      cfg.speed_step       = SPEED_STEP_RESET;
      cfg.slow_drop        = SLOW_DROP_RESET;
      cfg.short_move_limit = SHORT_MOVE_LIMIT_RESET;
      cfg.min_ramp_ticks   = MIN_RAMP_TICKS_RESET;
      move_phase   = PH_IDLE;
      move_mode    = '0;
      ramp_speed   = '0;
      cruise_speed = '0;
      target_ticks = '0;
      ramp_end     = '0;
      cruise_end   = '0;
      wheel_cmd_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_MIN_SPEED:        cfg.min_speed        = pwdata[10:0];
          REG_SPEED_STEP:       cfg.speed_step       = pwdata[7:0];
          REG_SLOW_DROP:        cfg.slow_drop        = pwdata[10:0];
          REG_SHORT_MOVE_LIMIT: cfg.short_move_limit = pwdata[19:0];
          REG_MIN_RAMP_TICKS:   cfg.min_ramp_ticks   = pwdata[19:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.front_left_speed  = m_tdata[11:0];
        got.back_left_speed   = m_tdata[23:12];
        got.front_right_speed = m_tdata[35:24];
        got.back_right_speed  = m_tdata[47:36];
        got.phase             = phase_t'(m_tdata[50:48]);
        got.finished          = m_tlast;
        if (wheel_cmd_due.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected, actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = wheel_cmd_due.pop_front();
          compare_field("front_left_speed", int'($signed(want.front_left_speed)),
                        int'($signed(got.front_left_speed)));
          compare_field("back_left_speed", int'($signed(want.back_left_speed)),
                        int'($signed(got.back_left_speed)));
          compare_field("front_right_speed", int'($signed(want.front_right_speed)),
                        int'($signed(got.front_right_speed)));
          compare_field("back_right_speed", int'($signed(want.back_right_speed)),
                        int'($signed(got.back_right_speed)));
          compare_field("phase", int'(want.phase), int'(got.phase));
          compare_field("finished", int'(want.finished), int'(got.finished));
        end
      end
      if (s_tvalid && s_tready) begin
        item.kind      = s_tuser[0];
        item.distance  = s_tdata[19:0];
        item.top_speed = s_tdata[30:20];
        item.direction = s_tdata[32:31];
        item.position  = s_tdata[64:33];
        wheel_cmd_due.push_back(next_wheel_cmd(item));
      end
    end
    cmds_due <= wheel_cmd_due.size();
  end

endmodule

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 160;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int cmds_due;
  int cycle_count = 0;
  int words_sent = 0;
  bit idling = 1'b1;
  bit sink_hold_req = 1'b0;

  trapezoid_drive_profile_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drive_profile_checker profile_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .cmds_due(cmds_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("trapezoid_drive_profile_unit regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic kind, logic [19:0] dist_in, logic [10:0] top,
                           logic [1:0] dir, logic [31:0] pos);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, pos, dir, top, dist_in};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (cmds_due != 0);
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one start word, then odometer ticks marching toward the target
  task automatic run_move();
    logic [19:0] move_len;
    logic [10:0] top;
    logic [1:0]  dir;
    longint      prog, stride, pos;
    int          n;
    case ($urandom_range(0, 9))
      0, 1: move_len = 20'($urandom_range(0, 20));
      8: move_len = 20'($urandom);
      9: move_len = 20'($urandom_range(0, 5000));
      default: move_len = 20'($urandom_range(21, 600));
    endcase
    if ($urandom_range(0, 9) == 0) top = 11'($urandom_range(1501, 2047));
    else top = 11'($urandom_range(0, 1500));
    dir = 2'($urandom);
    send_word(KIND_START, move_len, top, dir, $urandom);
    stride = move_len / 10 + 1;
    prog = 0;
    n = $urandom_range(6, 30);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: prog = prog - longint'($urandom_range(0, 32'(stride)));
        1: prog = longint'(move_len) + $urandom_range(0, 3);
        default: prog = prog + $urandom_range(0, 32'(2 * stride));
      endcase
      // strafes read |position|, so either sign must work
      if (dir == DIR_BACKWARD || (dir[1] && $urandom_range(0, 1) == 1)) pos = -prog;
      else pos = prog;
      send_word(KIND_TICK, 20'($urandom), 11'($urandom), 2'($urandom), 32'(pos));
      if (prog >= longint'(move_len)) break;
    end
    if ($urandom_range(0, 1) == 0) begin
      send_word(KIND_TICK, 20'($urandom), 11'($urandom), 2'($urandom), $urandom);
    end
  endtask

  initial begin : sink
    int span;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        span = 60;
      end else if (idling && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        span = $urandom_range(1, 6);
      end else begin
        m_tready <= 1'b1;
        span = idling ? $urandom_range(1, 8) : 1;
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    int          ph, phase_start;
    logic [10:0] ms, sd;
    logic [7:0]  st;
    logic [19:0] sl, mr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick with no move loaded
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd0);
    // zero distance brakes on the first tick
    send_word(KIND_START, 20'd0, 11'd1500, DIR_FORWARD, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd0);
    // longest move, zero top speed, backward; most negative position overshoots
    send_word(KIND_START, 20'hFFFFF, 11'd0, DIR_BACKWARD, 32'hFFFF_FFFF);
    send_word(KIND_TICK, 20'hFFFFF, 11'h7FF, DIR_STRAFE_LEFT, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'h8000_0000);
    // short strafe right through every phase
    send_word(KIND_START, 20'd150, 11'd1500, DIR_STRAFE_RIGHT, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd10);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd60);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd120);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'h7FFF_FFFF);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd5);
    // forward ramp with backward slip, then restart mid-move
    send_word(KIND_START, 20'd300, 11'd800, DIR_FORWARD, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd1);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd5);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd10);
    // distance at the short move limit, top speed out of range, strafe left
    send_word(KIND_START, 20'd200, 11'd2047, DIR_STRAFE_LEFT, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd100);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd200);
    // tiny backward move, one tick per phase
    send_word(KIND_START, 20'd5, 11'd1000, DIR_BACKWARD, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, 32'd0);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd2);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd4);
    send_word(KIND_TICK, 20'd0, 11'd0, DIR_FORWARD, -32'sd5);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          ms = 11'd0; st = 8'd1; sd = 11'd0; sl = 20'd0; mr = 20'd0;
        end
        1: begin
          ms = 11'd1500; st = 8'd255; sd = 11'd1500; sl = 20'hFFFFF; mr = 20'hFFFFF;
        end
        2: begin
          ms = 11'($urandom_range(0, 1500));
          st = 8'($urandom_range(1, 255));
          sd = 11'($urandom_range(0, 1500));
          sl = 20'($urandom_range(0, 2000));
          mr = 20'($urandom_range(0, 300));
        end
        3: begin
          ms = 11'($urandom_range(0, 1500));
          st = 8'($urandom_range(1, 255));
          sd = 11'($urandom_range(0, 1500));
          sl = 20'($urandom);
          mr = 20'($urandom);
        end
        default: begin
          ms = MIN_SPEED_RESET; st = SPEED_STEP_RESET; sd = SLOW_DROP_RESET;
          sl = SHORT_MOVE_LIMIT_RESET; mr = MIN_RAMP_TICKS_RESET;
        end
      endcase
      reg_write(REG_MIN_SPEED, 32'(ms));
      reg_write(REG_SPEED_STEP, 32'(st));
      reg_write(REG_SLOW_DROP, 32'(sd));
      reg_write(REG_SHORT_MOVE_LIMIT, 32'(sl));
      reg_write(REG_MIN_RAMP_TICKS, 32'(mr));
      if (ph == 4) idling = 1'b0;

      phase_start = words_sent;
      if (ph == 0) begin
        // sink holds off while words keep coming, so the input backs up
        idling = 1'b0;
        sink_hold_req = 1'b1;
        run_move();
        run_move();
        idling = 1'b1;
      end
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_word(1'($urandom), 20'($urandom), 11'($urandom_range(0, 1500)),
                      2'($urandom), $urandom);
          end
        end else begin
          run_move();
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("trapezoid_drive_profile_unit regression: pass");
    end else begin
      $display("trapezoid_drive_profile_unit regression: fail");
    end
    $finish;
  end

endmodule
